>>> src/pcg_pkg.sv
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared types and constants for the proximity collision grader.
// ----------------------------------------------------------------------------
package pcg_pkg;

  // zone codes
  localparam logic [1:0] ZID_FRONT = 2'd0;
  localparam logic [1:0] ZID_BACK  = 2'd1;
  localparam logic [1:0] ZID_LEFT  = 2'd2;
  localparam logic [1:0] ZID_RIGHT = 2'd3;

  // severity codes
  localparam logic [1:0] SEV_NONE     = 2'd0;
  localparam logic [1:0] SEV_WARNING  = 2'd1;
  localparam logic [1:0] SEV_CRITICAL = 2'd2;
  localparam logic [1:0] SEV_IMMINENT = 2'd3;

  // config register map (index = paddr[4:2])
  localparam int unsigned CFG_AW = 5;
  localparam logic [2:0] REG_WARNING  = 3'd0;
  localparam logic [2:0] REG_CRITICAL = 3'd1;
  localparam logic [2:0] REG_IMMINENT = 3'd2;
  localparam logic [2:0] REG_MAX_RNG  = 3'd3;
  localparam logic [2:0] REG_APPROACH = 3'd4;
  localparam logic [2:0] REG_PREDICT  = 3'd5;

  // reset values
  localparam logic [14:0] RST_WARNING  = 15'd500;
  localparam logic [14:0] RST_CRITICAL = 15'd300;
  localparam logic [14:0] RST_IMMINENT = 15'd150;
  localparam logic [14:0] RST_MAX_RNG  = 15'd4000;
  localparam logic [14:0] RST_APPROACH = 15'd200;
  localparam logic        RST_PREDICT  = 1'b1;
  localparam logic signed [15:0] RST_LAST_MM = 16'sd9999;

  // mm/s vs mm/ms scaling
  localparam logic signed [27:0] MS_PER_S = 28'sd1000;

  typedef struct packed {
    logic               vld;
    logic signed [15:0] mm;
  } lane_t;

  typedef struct packed {
    logic [14:0] warning_mm;
    logic [14:0] critical_mm;
    logic [14:0] imminent_mm;
    logic [14:0] max_range_mm;
  } thr_t;

endpackage

>>> src/pcg_if.sv
// ----------------------------------------------------------------------------
// pcg_if
// Valid/ready channels for reading sets and graded results.
// ----------------------------------------------------------------------------
interface pcg_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] front_mm;
  logic signed [15:0] back_mm;
  logic signed [15:0] left_mm;
  logic signed [15:0] right_mm;
  logic [15:0]        elapsed_ms;

  modport source (output valid, front_mm, back_mm, left_mm, right_mm, elapsed_ms,
                  input ready);
  modport sink (input valid, front_mm, back_mm, left_mm, right_mm, elapsed_ms,
                output ready);
endinterface

interface pcg_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         zone;
  logic signed [15:0] closest_mm;
  logic [1:0]         severity;
  logic               detected;

  modport source (output valid, zone, closest_mm, severity, detected, input ready);
  modport sink (input valid, zone, closest_mm, severity, detected, output ready);
endinterface

>>> src/proximity_collision_grader.sv
// ----------------------------------------------------------------------------
// proximity_collision_grader
// Takes one set of four range readings per transaction, picks the closest
// zone (front unless another zone has a positive, strictly smaller reading),
// grades it against the warning/critical/imminent thresholds and, when
// prediction is on and elapsed_ms is nonzero, raises a warning or critical
// grade one level on a fast approach (change*1000 < -limit*elapsed_ms,
// exact, no division). Throughput is one transaction per clock while the
// output is not stalled. A transaction passes through three register
// stages: select + rate product, per-zone history read/update + grading,
// then the x1000 compare and upgrade into the output register. The
// four-entry history lives in flops and, when prediction applies, is
// updated as a transaction moves from the first stage into the second, so
// the next transaction always sees the previous write.
// Each stage has its own valid bit and fills independently, so input is
// taken while a finished result waits at the output. Config is APB at byte
// address 4*index; writes are meant to happen only while the block is idle.
// ----------------------------------------------------------------------------
module proximity_collision_grader (
  input  logic                        clk,
  input  logic                        rst_n,
  pcg_in_if.sink                      in_ch,
  pcg_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pcg_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import pcg_pkg::*;

  // --------------------------------------------------------------------------
  // config registers
  // --------------------------------------------------------------------------
  logic [14:0] warning_r, critical_r, imminent_r, max_rng_r, approach_r;
  logic        predict_r;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;
  thr_t        thr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warning_r  <= RST_WARNING;
      critical_r <= RST_CRITICAL;
      imminent_r <= RST_IMMINENT;
      max_rng_r  <= RST_MAX_RNG;
      approach_r <= RST_APPROACH;
      predict_r  <= RST_PREDICT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WARNING:  warning_r  <= cfg_pwdata[14:0];
        REG_CRITICAL: critical_r <= cfg_pwdata[14:0];
        REG_IMMINENT: imminent_r <= cfg_pwdata[14:0];
        REG_MAX_RNG:  max_rng_r  <= cfg_pwdata[14:0];
        REG_APPROACH: approach_r <= cfg_pwdata[14:0];
        REG_PREDICT:  predict_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WARNING:  cfg_prdata = {17'd0, warning_r};
      REG_CRITICAL: cfg_prdata = {17'd0, critical_r};
      REG_IMMINENT: cfg_prdata = {17'd0, imminent_r};
      REG_MAX_RNG:  cfg_prdata = {17'd0, max_rng_r};
      REG_APPROACH: cfg_prdata = {17'd0, approach_r};
      REG_PREDICT:  cfg_prdata = {31'd0, predict_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  assign thr.warning_mm   = warning_r;
  assign thr.critical_mm  = critical_r;
  assign thr.imminent_mm  = imminent_r;
  assign thr.max_range_mm = max_rng_r;

  // --------------------------------------------------------------------------
  // pipeline handshake: each stage loads when empty or draining
  // --------------------------------------------------------------------------
  logic a_vld_r, b_vld_r, c_vld_r;
  logic a_rdy, b_rdy, c_rdy;
  logic a_load, b_load, c_load;

  assign c_rdy  = !c_vld_r || out_ch.ready;
  assign b_rdy  = !b_vld_r || c_rdy;
  assign a_rdy  = !a_vld_r || b_rdy;
  assign in_ch.ready = a_rdy;

  assign a_load = in_ch.valid && a_rdy;
  assign b_load = a_vld_r && b_rdy;
  assign c_load = b_vld_r && c_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      if (a_load)      a_vld_r <= 1'b1;
      else if (b_load) a_vld_r <= 1'b0;
      if (b_load)      b_vld_r <= 1'b1;
      else if (c_load) b_vld_r <= 1'b0;
      if (c_load)      c_vld_r <= 1'b1;
      else if (out_ch.ready) c_vld_r <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // stage A: lanes + merge, rate product
  // --------------------------------------------------------------------------
  lane_t [3:0]        lanes;
  logic [1:0]         sel_zone;
  logic signed [15:0] sel_mm;
  logic [30:0]        prod_nxt;

  pcg_lane u_lane_front (.mm(in_ch.front_mm), .lane(lanes[0]));
  pcg_lane u_lane_back  (.mm(in_ch.back_mm),  .lane(lanes[1]));
  pcg_lane u_lane_left  (.mm(in_ch.left_mm),  .lane(lanes[2]));
  pcg_lane u_lane_right (.mm(in_ch.right_mm), .lane(lanes[3]));

  pcg_merge u_merge (
    .lanes   (lanes),
    .zone    (sel_zone),
    .best_mm (sel_mm)
  );

  // limit (15b) * elapsed (16b) fits in 31 bits unsigned
  assign prod_nxt = {16'd0, approach_r} * {15'd0, in_ch.elapsed_ms};

  logic [1:0]         a_zone_r;
  logic signed [15:0] a_mm_r;
  logic               a_pred_r;
  logic [30:0]        a_prod_r;

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_zone_r <= sel_zone;
      a_mm_r   <= sel_mm;
      a_pred_r <= predict_r && (in_ch.elapsed_ms != 16'd0);
      a_prod_r <= prod_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage B: history read/update, distance grade
  // --------------------------------------------------------------------------
  logic signed [15:0] last_mm_r [4];
  logic signed [15:0] last_rd;
  logic signed [16:0] change_nxt;
  logic [1:0]         sev_nxt;

  assign last_rd    = last_mm_r[a_zone_r];
  assign change_nxt = {a_mm_r[15], a_mm_r} - {last_rd[15], last_rd};

  pcg_grade u_grade (
    .mm  (a_mm_r),
    .thr (thr),
    .sev (sev_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        last_mm_r[i] <= RST_LAST_MM;
      end
    end else if (b_load && a_pred_r) begin
      last_mm_r[a_zone_r] <= a_mm_r;
    end
  end

  logic [1:0]         b_zone_r;
  logic signed [15:0] b_mm_r;
  logic [1:0]         b_sev_r;
  logic               b_pred_r;
  logic signed [16:0] b_change_r;
  logic [30:0]        b_prod_r;

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_zone_r   <= a_zone_r;
      b_mm_r     <= a_mm_r;
      b_sev_r    <= sev_nxt;
      b_pred_r   <= a_pred_r;
      b_change_r <= change_nxt;
      b_prod_r   <= a_prod_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage C: fast-approach compare and upgrade into output register
  // --------------------------------------------------------------------------
  logic signed [27:0] lhs;
  logic signed [32:0] lhs_x, rhs_x;
  logic               fast;
  logic [1:0]         sev_up;

  assign lhs   = {{11{b_change_r[16]}}, b_change_r} * MS_PER_S;
  assign lhs_x = {{5{lhs[27]}}, lhs};
  assign rhs_x = -$signed({2'b00, b_prod_r});
  assign fast  = b_pred_r && (lhs_x < rhs_x);

  always_comb begin
    case (b_sev_r)
      SEV_WARNING:  sev_up = fast ? SEV_CRITICAL : SEV_WARNING;
      SEV_CRITICAL: sev_up = fast ? SEV_IMMINENT : SEV_CRITICAL;
      default:      sev_up = b_sev_r;
    endcase
  end

  logic [1:0]         c_zone_r;
  logic signed [15:0] c_mm_r;
  logic [1:0]         c_sev_r;
  logic               c_det_r;

  always_ff @(posedge clk) begin
    if (c_load) begin
      c_zone_r <= b_zone_r;
      c_mm_r   <= b_mm_r;
      c_sev_r  <= sev_up;
      c_det_r  <= (b_sev_r != SEV_NONE);
    end
  end

  assign out_ch.valid      = c_vld_r;
  assign out_ch.zone       = c_zone_r;
  assign out_ch.closest_mm = c_mm_r;
  assign out_ch.severity   = c_sev_r;
  assign out_ch.detected   = c_det_r;

endmodule

>>> src/pcg_lane.sv
// ----------------------------------------------------------------------------
// pcg_lane
// Per-zone candidate check: a reading competes only when positive.
// ----------------------------------------------------------------------------
module pcg_lane (
  input  logic signed [15:0] mm,
  output pcg_pkg::lane_t     lane
);
  import pcg_pkg::*;

  always_comb begin
    lane.mm  = mm;
    lane.vld = (mm > 16'sd0);
  end

endmodule

>>> src/pcg_merge.sv
// ----------------------------------------------------------------------------
// pcg_merge
// Two-level select tree over the four lanes. Front is always a candidate;
// ties resolve to the lower zone index.
// ----------------------------------------------------------------------------
module pcg_merge (
  input  pcg_pkg::lane_t [3:0] lanes,
  output logic [1:0]           zone,
  output logic signed [15:0]   best_mm
);
  import pcg_pkg::*;

  logic [1:0]         z01, z23;
  logic signed [15:0] m01, m23;
  logic               v23;

  always_comb begin
    // front vs back
    if (lanes[1].vld && (lanes[1].mm < lanes[0].mm)) begin
      z01 = ZID_BACK;
      m01 = lanes[1].mm;
    end else begin
      z01 = ZID_FRONT;
      m01 = lanes[0].mm;
    end

    // left vs right
    v23 = lanes[2].vld | lanes[3].vld;
    if (lanes[3].vld && (!lanes[2].vld || (lanes[3].mm < lanes[2].mm))) begin
      z23 = ZID_RIGHT;
      m23 = lanes[3].mm;
    end else begin
      z23 = ZID_LEFT;
      m23 = lanes[2].mm;
    end

    // final pick, side pair wins only when strictly closer
    if (v23 && (m23 < m01)) begin
      zone    = z23;
      best_mm = m23;
    end else begin
      zone    = z01;
      best_mm = m01;
    end
  end

endmodule

>>> src/pcg_grade.sv
// ----------------------------------------------------------------------------
// pcg_grade
// Grades a distance against the three thresholds and the max range.
// ----------------------------------------------------------------------------
module pcg_grade (
  input  logic signed [15:0] mm,
  input  pcg_pkg::thr_t      thr,
  output logic [1:0]         sev
);
  import pcg_pkg::*;

  logic signed [15:0] warn_s, crit_s, imm_s, max_s;

  always_comb begin
    warn_s = $signed({1'b0, thr.warning_mm});
    crit_s = $signed({1'b0, thr.critical_mm});
    imm_s  = $signed({1'b0, thr.imminent_mm});
    max_s  = $signed({1'b0, thr.max_range_mm});
    if ((mm < 16'sd0) || (mm > max_s)) begin
      sev = SEV_NONE;
    end else if (mm < imm_s) begin
      sev = SEV_IMMINENT;
    end else if (mm < crit_s) begin
      sev = SEV_CRITICAL;
    end else if (mm < warn_s) begin
      sev = SEV_WARNING;
    end else begin
      sev = SEV_NONE;
    end
  end

endmodule

>>> verif/pcg_grade_checker.sv
// ----------------------------------------------------------------------------
// pcg_grade_checker
// Watches the reading and result channels and the APB port of the collision
// grader. It keeps its own copy of the thresholds and of the per-zone
// distance history, predicts the graded result of each accepted reading set
// and compares every accepted result, field by field, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module pcg_grade_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  pcg_in_if                           in_mon,
  pcg_out_if                          out_mon,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic                        cfg_pready,
  input  logic [pcg_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output int                          mismatches,
  output int                          awaiting,
  output int                          graded
);
  timeunit 1ns;
  timeprecision 1ps;

  import pcg_pkg::*;

  typedef struct packed {
    logic [1:0]         zone;
    logic signed [15:0] mm;
    logic [1:0]         sev;
    logic               det;
  } grade_t;

  // reading lane order: front, back, left, right
  localparam logic [1:0] LANE_ZONE [4] = '{ZID_FRONT, ZID_BACK, ZID_LEFT, ZID_RIGHT};

  logic [14:0]        warn_thr, crit_thr, imm_thr, range_max, rate_limit;
  logic               predict_en;
  logic signed [15:0] zone_hist [4];
  grade_t             pending_grades [$];

  function automatic logic [1:0] distance_grade(input logic signed [15:0] d);
    int dv;
    dv = d;
    if (dv < 0 || dv > int'(range_max)) return SEV_NONE;
    if (dv < int'(imm_thr))  return SEV_IMMINENT;
    if (dv < int'(crit_thr)) return SEV_CRITICAL;
    if (dv < int'(warn_thr)) return SEV_WARNING;
    return SEV_NONE;
  endfunction

  // closest zone, grade, then approach-rate upgrade; updates zone_hist
  function automatic grade_t grade_readings(input logic signed [15:0] f, b, l, r,
                                            input logic [15:0] el);
    logic signed [15:0] reading [4];
    logic signed [15:0] best;
    logic [1:0]         z;
    logic [1:0]         sev;
    longint             delta, closing, bound;
    grade_t             g;
    reading[0] = f;
    reading[1] = b;
    reading[2] = l;
    reading[3] = r;
    best = f;
    z = ZID_FRONT;
    for (int k = 1; k < 4; k++) begin
      if (reading[k] > 0 && reading[k] < best) begin
        best = reading[k];
        z = LANE_ZONE[k];
      end
    end
    sev = distance_grade(best);
    g.det = (sev != SEV_NONE);
    if (predict_en && el != 16'd0) begin
      delta   = longint'(best) - longint'(zone_hist[z]);
      closing = delta * longint'(MS_PER_S);
      bound   = -(longint'(rate_limit) * longint'(el));
      zone_hist[z] = best;
      if (closing < bound) begin
        if (sev == SEV_WARNING) sev = SEV_CRITICAL;
        else if (sev == SEV_CRITICAL) sev = SEV_IMMINENT;
      end
    end
    g.zone = z;
    g.mm   = best;
    g.sev  = sev;
    return g;
  endfunction

  task automatic check_field(input string field, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    grade_t want;
    if (!rst_n) begin
      warn_thr   = RST_WARNING;
      crit_thr   = RST_CRITICAL;
      imm_thr    = RST_IMMINENT;
      range_max  = RST_MAX_RNG;
      rate_limit = RST_APPROACH;
      predict_en = RST_PREDICT;
      for (int k = 0; k < 4; k++) zone_hist[k] = RST_LAST_MM;
      pending_grades.delete();
      mismatches = 0;
      graded     = 0;
      awaiting   = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_WARNING:  warn_thr   = cfg_pwdata[14:0];
          REG_CRITICAL: crit_thr   = cfg_pwdata[14:0];
          REG_IMMINENT: imm_thr    = cfg_pwdata[14:0];
          REG_MAX_RNG:  range_max  = cfg_pwdata[14:0];
          REG_APPROACH: rate_limit = cfg_pwdata[14:0];
          REG_PREDICT:  predict_en = cfg_pwdata[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_grades.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result zone %0d mm %0d severity %0d detected %0d",
                   $time, out_mon.zone, out_mon.closest_mm, out_mon.severity,
                   out_mon.detected);
        end else begin
          want = pending_grades.pop_front();
          check_field("zone", want.zone, out_mon.zone);
          check_field("closest_mm", want.mm, out_mon.closest_mm);
          check_field("severity", want.sev, out_mon.severity);
          check_field("detected", want.det, out_mon.detected);
          graded++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_grades.push_back(grade_readings(in_mon.front_mm, in_mon.back_mm,
                                                in_mon.left_mm, in_mon.right_mm,
                                                in_mon.elapsed_ms));
      awaiting = pending_grades.size();
    end
  end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top level for the proximity collision grader. Drives reading sets and the
// result-side ready with random idle gaps, programs the thresholds over APB
// between phases, and leaves all prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NUM_PHASES  = 9;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam int unsigned LONG_HOLD   = 60;
  // addresses past the register map; writes there must be dropped
  localparam logic [2:0]  REG_SPARE_6 = 3'd6;
  localparam logic [2:0]  REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [15:0] front_mm;
    logic signed [15:0] back_mm;
    logic signed [15:0] left_mm;
    logic signed [15:0] right_mm;
    logic [15:0]        elapsed_ms;
  } readings_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  int mismatches;
  int awaiting;
  int graded;
  int sent;
  int cycles;
  int hold_cycles;   // receiver stall request, consumed by the receiver
  bit tx_eager;      // sender offers back to back
  bit rx_eager;      // receiver never drops ready on its own

  // approach-run state: one zone closing in over several transactions
  int run_zone;
  int run_dist;
  int run_left;

  pcg_in_if  in_ch ();
  pcg_out_if out_ch ();

  proximity_collision_grader dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pcg_grade_checker grade_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .mismatches  (mismatches),
    .awaiting    (awaiting),
    .graded      (graded)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding", cycles, awaiting);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // APB write: setup phase, access phase, then an idle phase with psel low so
  // that a following write never toggles psel twice in one step.
  // --------------------------------------------------------------------------
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits carry junk so that masking to the register width is hit.
  task automatic program_thresholds(input int warn, crit, imm, maxr, limit,
                                    input bit predict);
    cfg_write(REG_WARNING,  {17'($urandom()), 15'(warn)});
    cfg_write(REG_CRITICAL, {17'($urandom()), 15'(crit)});
    cfg_write(REG_IMMINENT, {17'($urandom()), 15'(imm)});
    cfg_write(REG_MAX_RNG,  {17'($urandom()), 15'(maxr)});
    cfg_write(REG_APPROACH, {17'($urandom()), 15'(limit)});
    cfg_write(REG_PREDICT,  {31'($urandom()), predict});
  endtask

  // --------------------------------------------------------------------------
  // Sender: optional idle gap, then hold the transaction until accepted.
  // valid stays high into the next transaction when the next gap is zero.
  // --------------------------------------------------------------------------
  task automatic send_readings(input readings_t rd);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.front_mm   <= rd.front_mm;
    in_ch.back_mm    <= rd.back_mm;
    in_ch.left_mm    <= rd.left_mm;
    in_ch.right_mm   <= rd.right_mm;
    in_ch.elapsed_ms <= rd.elapsed_ms;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // Stop offering and wait until every predicted result has been taken.
  // The extra edge lets the checker count the last accepted transaction.
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (awaiting == 0);
    @(posedge clk);
  endtask

  function automatic readings_t rs(input int f, b, l, r, e);
    readings_t rd;
    rd.front_mm   = 16'(f);
    rd.back_mm    = 16'(b);
    rd.left_mm    = 16'(l);
    rd.right_mm   = 16'(r);
    rd.elapsed_ms = 16'(e);
    return rd;
  endfunction

  function automatic logic signed [15:0] noise_mm();
    case ($urandom_range(0, 4))
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 1200));
      2: return 16'(-int'($urandom_range(0, 300)));
      3: begin
        case ($urandom_range(0, 4))
          0: return 16'sd0;
          1: return 16'sd1;
          2: return -16'sd1;
          3: return 16'sh7fff;
          default: return 16'sh8000;
        endcase
      end
      default: return 16'($urandom_range(1, 4500));
    endcase
  endfunction

  // a zone other than the closing one: farther away, or an invalid reading
  function automatic logic signed [15:0] farther_or_invalid(input int d);
    if ($urandom_range(0, 2) == 0) return 16'(-int'($urandom_range(0, 50)));
    return 16'(d + $urandom_range(1, 3000));
  endfunction

  // Mostly approach runs (same zone closing in), the rest unstructured noise.
  function automatic readings_t next_readings();
    readings_t rd;
    if (run_left == 0 && $urandom_range(0, 9) < 7) begin
      run_zone = $urandom_range(0, 3);
      run_dist = $urandom_range(100, 3000);
      run_left = $urandom_range(4, 12);
    end
    if (run_left > 0) begin
      run_left--;
      run_dist -= $urandom_range(0, 180);
      if (run_dist < 1) run_dist = 1;
      rd.front_mm = 16'(run_dist + $urandom_range(1, 3000));
      rd.back_mm  = farther_or_invalid(run_dist);
      rd.left_mm  = farther_or_invalid(run_dist);
      rd.right_mm = farther_or_invalid(run_dist);
      case (run_zone)
        0: rd.front_mm = 16'(run_dist);
        1: rd.back_mm  = 16'(run_dist);
        2: rd.left_mm  = 16'(run_dist);
        default: rd.right_mm = 16'(run_dist);
      endcase
      rd.elapsed_ms = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 400));
    end else begin
      rd.front_mm = noise_mm();
      rd.back_mm  = noise_mm();
      rd.left_mm  = noise_mm();
      rd.right_mm = noise_mm();
      case ($urandom_range(0, 3))
        0: rd.elapsed_ms = 16'd0;
        1: rd.elapsed_ms = 16'($urandom());
        2: rd.elapsed_ms = 16'hffff;
        default: rd.elapsed_ms = 16'($urandom_range(1, 500));
      endcase
    end
    return rd;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stall before each result, plus a long hold-off when
  // the stimulus asks for one, counted here in cycles.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = rx_eager ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // --------------------------------------------------------------------------
  // Main stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int warn, crit, imm, maxr, limit, tmp;
    bit predict;
    in_ch.valid      <= 1'b0;
    in_ch.front_mm   <= '0;
    in_ch.back_mm    <= '0;
    in_ch.left_mm    <= '0;
    in_ch.right_mm   <= '0;
    in_ch.elapsed_ms <= '0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    rst_n            <= 1'b0;
    tx_eager    = 1'b0;
    rx_eager    = 1'b0;
    hold_cycles = 0;
    run_left    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset thresholds (warn 500, crit 300, imm 150, range
    // 4000, limit 200 mm/s), history 9999 everywhere.
    send_readings(rs(0, 0, 0, 0, 0));                  // front zero still chosen
    send_readings(rs(-32768, -1, -32768, 0, 0));       // negative front, grades none
    send_readings(rs(32767, 32767, 32767, 32767, 65535));
    send_readings(rs(5000, 800, 900, 1000, 10));       // back wins; fast but none stays none
    send_readings(rs(5000, 6000, 450, 460, 1));        // left warning upgraded to critical
    send_readings(rs(600, 700, 800, 250, 1));          // right critical upgraded to imminent
    send_readings(rs(100, 100, 100, 100, 50));         // tie keeps front; imminent stays
    send_readings(rs(4001, 0, -5, 0, 0));              // above range, no history update
    send_readings(rs(4000, 0, 0, 0, 5));               // exactly at range limit
    send_readings(rs(499, 0, 0, 0, 0));                // zero elapsed: plain warning
    send_readings(rs(499, 0, 0, 0, 1));                // fast approach from 4000
    send_readings(rs(299, 0, 0, 0, 1000));             // change*1000 equals the bound: no upgrade
    send_readings(rs(298, 0, 0, 0, 1000));             // slow approach
    send_readings(rs(149, 0, 0, 0, 1));                // fast, but imminent is the top
    send_readings(rs(300, 0, 0, 0, 1));                // receding, warning
    send_readings(rs(-100, -200, 0, 50, 3));           // negative front beats positive right
    send_readings(rs(32767, -1, 0, 1, 65535));         // right at 1 mm
    send_readings(rs(200, 199, 198, 197, 2));
    send_readings(rs(-32768, 16384, 8192, 4096, 43690));
    send_readings(rs(21845, -21846, 10922, -10923, 21845));
    drain();

    // Random phases, each under its own register setting.
    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      case (phase)
        1: program_thresholds(32767, 32767, 32767, 32767, 32767, 1'b1);
        2: program_thresholds(0, 0, 0, 0, 0, 1'b1);
        3: program_thresholds(RST_WARNING, RST_CRITICAL, RST_IMMINENT, RST_MAX_RNG,
                              RST_APPROACH, 1'b0);
        4: program_thresholds(RST_WARNING, RST_CRITICAL, RST_IMMINENT, RST_MAX_RNG,
                              RST_APPROACH, RST_PREDICT);
        default: begin
          imm  = $urandom_range(0, 600);
          crit = imm + $urandom_range(0, 600);
          warn = crit + $urandom_range(0, 800);
          maxr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                             : warn + $urandom_range(0, 4000);
          limit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                              : $urandom_range(0, 1000);
          predict = ($urandom_range(0, 4) != 0);
          // sometimes leave the thresholds out of order
          if ($urandom_range(0, 3) == 0) begin
            tmp  = warn;
            warn = imm;
            imm  = tmp;
          end
          program_thresholds(warn, crit, imm, maxr, limit, predict);
          if (phase == 5) begin
            cfg_write(REG_SPARE_6, $urandom());
            cfg_write(REG_SPARE_7, $urandom());
          end
        end
      endcase

      tx_eager = ($urandom_range(0, 2) == 0);
      rx_eager = ($urandom_range(0, 2) == 0);
      // back-pressure phase: receiver holds off while the sender keeps going
      if (phase == 4) begin
        tx_eager    = 1'b1;
        hold_cycles = LONG_HOLD;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_readings(next_readings());
      drain();
    end

    // outstanding results are zero here; allow the pipeline to settle
    repeat (10) @(posedge clk);
    $display("Covered %0d reading sets over %0d register settings plus reset values,",
             sent, NUM_PHASES);
    $display("  %0d graded results compared, incl. threshold extremes and a stall.", graded);
    if (mismatches == 0 && awaiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/pcg_pkg.sv
src/pcg_if.sv
src/pcg_lane.sv
src/pcg_merge.sv
src/pcg_grade.sv
src/proximity_collision_grader.sv
verif/pcg_grade_checker.sv
verif/tb.sv
